>>> sv/text_console_writer_core_defines.svh
// Assertion macros for the console writer checker
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// same-cycle implication, gated by reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tcw_pkg.sv
// Package: shared types and constants of the text console writer
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

  localparam int OPCODE_W   = 2;
  localparam int CHAR_W     = 8;
  localparam int NEW_ROW_W  = 5;
  localparam int NEW_COL_W  = 7;
  localparam int CELL_ADR_W = 11;
  localparam int ROW_OUT_W  = 5;
  localparam int COL_OUT_W  = 7;
  localparam int POS_OUT_W  = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = OPCODE_W;
  localparam int OUT_TDATA_W = 40;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OP_PUT_CHAR = 2'd0;
  localparam opcode_t OP_SET_POS  = 2'd1;
  localparam opcode_t OP_READ     = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_ATTRIBUTE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_ENABLE  = 1'd1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  typedef struct packed {
    logic latch_item;
    logic newline;
    logic put_write;
    logic set_pos;
    logic rd_issue;
    logic scroll_start;
    logic scroll_step;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    col_full;
    logic    row_last;
    logic    is_newline;
    logic    scroll_last;
  } tcw_sts_t;

endpackage
`default_nettype wire

>>> sv/tcw_ctrl.sv
// Controller: sequences item handling, scrolls and result transfers
`timescale 1ns / 1ps
`default_nettype none
module tcw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t      cmd
);
  import tcw_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ret_finish_r, ret_finish_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) || ((state_r == ST_FINISH) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    ret_finish_nxt = ret_finish_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch_item = 1'b1;
          state_nxt      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_PUT_CHAR: begin
            if (sts.col_full) begin
              // line full: wrap first, then come back for the byte
              cmd.newline = 1'b1;
              if (sts.row_last) begin
                cmd.scroll_start = 1'b1;
                ret_finish_nxt   = 1'b0;
                state_nxt        = ST_SCROLL;
              end
            end else if (sts.is_newline) begin
              cmd.newline = 1'b1;
              if (sts.row_last) begin
                cmd.scroll_start = 1'b1;
                ret_finish_nxt   = 1'b1;
                state_nxt        = ST_SCROLL;
              end else begin
                state_nxt = ST_FINISH;
              end
            end else begin
              cmd.put_write = 1'b1;
              state_nxt     = ST_FINISH;
            end
          end
          OP_SET_POS: begin
            cmd.set_pos = 1'b1;
            state_nxt   = ST_FINISH;
          end
          OP_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = ST_FINISH;
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.scroll_last) begin
          state_nxt = ret_finish_r ? ST_FINISH : ST_EXEC;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          if (accept) begin
            cmd.latch_item = 1'b1;
            state_nxt      = ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_finish_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_finish_r <= ret_finish_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/tcw_datapath.sv
// Datapath: config registers, cursor, screen memory, scroll copy and result register
`timescale 1ns / 1ps
`default_nettype none
module tcw_datapath #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [tcw_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire tcw_pkg::tcw_cmd_t                 cmd,
  output tcw_pkg::tcw_sts_t                      sts,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import tcw_pkg::*;

  localparam int ROW_W      = $clog2(LAST_ROW + 1);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int CELL_COUNT = (LAST_ROW + 1) * COLUMNS;
  localparam int COPY_COUNT = LAST_ROW * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int POS_W      = $clog2(CELL_COUNT + 1);

  localparam logic [ROW_W-1:0] LAST_ROW_V = ROW_W'(LAST_ROW);
  localparam logic [COL_W-1:0] COLUMNS_V  = COL_W'(COLUMNS);

  // config
  logic [ATTR_W-1:0] attr_r;
  logic              cen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
      cen_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TEXT_ATTRIBUTE: attr_r <= cfg_wdata;
        REG_CURSOR_ENABLE:  cen_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item fields
  opcode_t               op_r;
  logic [CHAR_W-1:0]     ch_r;
  logic [NEW_ROW_W-1:0]  nrow_r;
  logic [NEW_COL_W-1:0]  ncol_r;
  logic [CELL_ADR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      op_r   <= in_tuser[OPCODE_W-1:0];
      ch_r   <= in_tdata[7:0];
      nrow_r <= in_tdata[12:8];
      ncol_r <= in_tdata[19:13];
      addr_r <= in_tdata[30:20];
    end
  end

  // cursor
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W+NEW_ROW_W-1:0] nrow_ext;
  logic [COL_W+NEW_COL_W-1:0] ncol_ext;
  logic [ROW_W-1:0] nrow_clamp;
  logic [COL_W-1:0] ncol_clamp;

  assign nrow_ext   = {{ROW_W{1'b0}}, nrow_r};
  assign ncol_ext   = {{COL_W{1'b0}}, ncol_r};
  assign nrow_clamp = (nrow_ext > (ROW_W + NEW_ROW_W)'(LAST_ROW)) ? LAST_ROW_V
                                                                  : nrow_ext[ROW_W-1:0];
  assign ncol_clamp = (ncol_ext > (COL_W + NEW_COL_W)'(COLUMNS)) ? COLUMNS_V
                                                                 : ncol_ext[COL_W-1:0];

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.newline) begin
      col_nxt = '0;
      if (row_r != LAST_ROW_V) begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
    if (cmd.put_write) begin
      col_nxt = col_r + COL_W'(1);
    end
    if (cmd.set_pos) begin
      row_nxt = nrow_clamp;
      col_nxt = ncol_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // linear position of the cursor
  logic [POS_W-1:0] cur_idx;
  assign cur_idx = POS_W'(row_r) * POS_W'(COLUMNS) + POS_W'(col_r);

  // read address check
  logic [ADDR_W+CELL_ADR_W-1:0] addr_ext;
  logic                         addr_ok;
  assign addr_ext = {{ADDR_W{1'b0}}, addr_r};
  assign addr_ok  = addr_ext < (ADDR_W + CELL_ADR_W)'(CELL_COUNT);

  // scroll pointer: write index, read issued one row and one cell ahead
  logic [ADDR_W-1:0] ptr_r;
  logic [ADDR_W:0]   src_addr;
  logic              src_ok;
  logic              copy_phase;

  assign src_addr   = {1'b0, ptr_r} + (ADDR_W + 1)'(COLUMNS + 1);
  assign src_ok     = src_addr < (ADDR_W + 1)'(CELL_COUNT);
  assign copy_phase = ptr_r < ADDR_W'(COPY_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.scroll_start) begin
      ptr_r <= '0;
    end else if (cmd.scroll_step) begin
      ptr_r <= ptr_r + ADDR_W'(1);
    end
  end

  // screen memory
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_r;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cur_idx[ADDR_W-1:0];
    wdata = {attr_r, ch_r};
    raddr = addr_ext[ADDR_W-1:0];
    if (cmd.put_write) begin
      we = 1'b1;
    end
    if (cmd.rd_issue) begin
      re = addr_ok;
    end
    if (cmd.scroll_start) begin
      re    = 1'b1;
      raddr = ADDR_W'(COLUMNS);
    end
    if (cmd.scroll_step) begin
      we    = 1'b1;
      waddr = ptr_r;
      wdata = copy_phase ? rdata_r : {attr_r, SPACE_CHAR};
      re    = src_ok;
      raddr = src_addr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  logic cell_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_ok_r <= 1'b0;
    end else if (cmd.latch_item) begin
      cell_ok_r <= 1'b0;
    end else if (cmd.rd_issue) begin
      cell_ok_r <= addr_ok;
    end
  end

  // result register
  logic [ROW_W+ROW_OUT_W-1:0] row_ext;
  logic [COL_W+COL_OUT_W-1:0] col_ext;
  logic [POS_W+POS_OUT_W-1:0] pos_ext;
  logic [POS_W-1:0]           pos;
  logic [OUT_TDATA_W-1:0]     out_data_r;

  assign pos     = cen_r ? cur_idx : '0;
  assign row_ext = {{ROW_OUT_W{1'b0}}, row_r};
  assign col_ext = {{COL_OUT_W{1'b0}}, col_r};
  assign pos_ext = {{POS_OUT_W{1'b0}}, pos};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {cell_ok_r ? rdata_r : {CELL_W{1'b0}},
                     cen_r,
                     pos_ext[POS_OUT_W-1:0],
                     col_ext[COL_OUT_W-1:0],
                     row_ext[ROW_OUT_W-1:0]};
    end
  end

  assign out_tdata = out_data_r;

  assign sts.op          = op_r;
  assign sts.col_full    = col_r >= COLUMNS_V;
  assign sts.row_last    = row_r == LAST_ROW_V;
  assign sts.is_newline  = ch_r == NEWLINE_CHAR;
  assign sts.scroll_last = ptr_r == ADDR_W'(CELL_COUNT - 1);

endmodule
`default_nettype wire

>>> sv/text_console_writer_core.sv
// Top level: text console writer, controller plus datapath
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  in_tdata, in_tuser (opcode)
//   out_     out  out_tvalid/out_tready out_tdata
//   cfg_     in   cfg_we               cfg_addr, cfg_wdata
//
// An item runs EXEC then FINISH, repeating EXEC when a put character first wraps a full
// line; the next item is taken in the cycle its predecessor's result enters the output
// register. A wrap or newline past the last row scrolls (LAST_ROW+1)*COLUMNS cells
// (2000 by default), one cell per cycle; a wrap and a newline in one item scroll twice.
// Reset needs no clearing pass; the screen is undefined until written.
// A stalled output holds its result; one further item is taken and held until then.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer_core #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] character, [12:8] new_row, [19:13] new_col, [30:20] cell_address
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] opcode
  input  wire logic [tcw_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [4:0] row, [11:5] column, [22:12] cursor_position, [23] cursor_shown,
  // [39:24] cell_data
  output logic [tcw_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .LAST_ROW (LAST_ROW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

>>> sv/tcw_checker.sv
// Checker: port-level assertions on result transfers, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_core_defines.svh"
module tcw_checker #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcw_pkg::*;

  `TCW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `TCW_ASSERT_NOW(a_row_range, out_tvalid, out_tdata[4:0] <= LAST_ROW, "row beyond last row")
  `TCW_ASSERT_NOW(a_col_range, out_tvalid, out_tdata[11:5] <= COLUMNS, "column beyond line end")
  `TCW_ASSERT_NOW(a_hidden_pos, out_tvalid && !out_tdata[23], out_tdata[22:12] == 11'd0, "hidden cursor reports a position")

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS  (COLUMNS),
  .LAST_ROW (LAST_ROW)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
